/* src/ripa_pkg.sv */
`timescale 1ns / 1ps
// Package for the resizable ID pool allocator: sizes, command codes and
// sequencer states. No dependencies.
package ripa_pkg;

    // ID space is fixed by the 8-bit ID fields
    localparam int ID_SPACE = 256;
    localparam int ID_W     = 8;
    localparam int CNT_W    = 9;

    localparam logic [CNT_W-1:0] POOL_MAX = CNT_W'(ID_SPACE);
    localparam logic [ID_W-1:0]  ID_LAST  = ID_W'(ID_SPACE - 1);

    // Request widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    typedef enum logic [1:0] {
        CMD_RENT   = 2'd0,
        CMD_RETURN = 2'd1,
        CMD_RESIZE = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_GROW
    } t_state;

endpackage

/* src/resizable_id_pool_allocator_unit.sv */
`timescale 1ns / 1ps
// Resizable ID pool allocator: FIFO free list and handed-out bitmap, both
// kept in single-port-write synchronous memories. Depends on ripa_pkg.
//
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------------------
//  s (in)   | in  | tuser: cmd[1:0]; tdata: returned_id[7:0], new_size[16:8]
//  m (out)  | out | tdata: ok[0], granted_id[8:1], free_count[17:9],
//           |     |        target_size[26:18], pending_retire[35:27],
//           |     |        ids_exhausted[36]
//
// Rent, return, query and shrinking or steady resize read both memories as
// the request is taken, then modify and write back in ST_EXEC. A growing
// resize then mints fresh IDs (up to 255) in ST_GROW via the single free-list
// write port. After reset a clearing pass zeroes both memories; no request is
// taken then. A request is taken only while the output register is empty or
// its result is taken at the same edge, so a stalled result holds the input.
module resizable_id_pool_allocator_unit
    import ripa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // returned_id[7:0], new_size[16:8]
    input  logic [S_TUSER_W-1:0] i_s_tuser,   // cmd[1:0]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata    // ok, granted_id, free_count,
                                              // target_size, pending_retire,
                                              // ids_exhausted
);

    // Storage
    logic [ID_W-1:0] fl_mem [ID_SPACE];
    logic            ho_mem [ID_SPACE];

    // Registers
    t_state           r_state,     n_state;
    logic [ID_W-1:0]  r_clr_cnt,   n_clr_cnt;
    t_cmd             r_cmd;
    logic [ID_W-1:0]  r_rid;
    logic [CNT_W-1:0] r_nsz;
    logic [ID_W-1:0]  r_fl_rdata;
    logic             r_ho_rdata;
    logic [ID_W-1:0]  r_head,      n_head;
    logic [CNT_W-1:0] r_tally,     n_tally;
    logic [CNT_W-1:0] r_fresh,     n_fresh;
    logic [CNT_W-1:0] r_target,    n_target;
    logic [CNT_W-1:0] r_backlog,   n_backlog;
    logic [CNT_W-1:0] r_grow_left, n_grow_left;
    logic             r_exh,       n_exh;
    logic             r_m_valid,   n_m_valid;
    logic [M_TDATA_W-1:0] r_m_tdata;

    // Combinational control
    logic             s_accept;
    logic             s_grow_go;
    logic             s_load;
    logic             s_ok;
    logic [ID_W-1:0]  s_gid;
    logic             s_exh;
    logic             fl_we;
    logic [ID_W-1:0]  fl_waddr;
    logic [ID_W-1:0]  fl_wdata;
    logic             ho_we;
    logic [ID_W-1:0]  ho_waddr;
    logic             ho_wdata;
    logic [CNT_W-1:0] nsz_sat;
    logic [CNT_W-1:0] need;
    logic [CNT_W-1:0] avail;
    logic [CNT_W-1:0] grow_cnt;
    logic [CNT_W-1:0] shrink_amt;
    logic [CNT_W-1:0] take;
    logic [ID_W-1:0]  push_addr;

    assign o_s_tready = (r_state == ST_IDLE) && (!r_m_valid || i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;

    // Resize arithmetic
    assign nsz_sat    = (r_nsz > POOL_MAX) ? POOL_MAX : r_nsz;
    assign need       = nsz_sat - r_target;
    assign avail      = POOL_MAX - r_fresh;
    assign grow_cnt   = (need > avail) ? avail : need;
    assign shrink_amt = r_target - nsz_sat;
    assign take       = (shrink_amt < r_tally) ? shrink_amt : r_tally;
    assign push_addr  = r_head + r_tally[ID_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == ID_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = s_grow_go ? ST_GROW : ST_IDLE;
            end
            ST_GROW: begin
                if (r_grow_left == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory write control
    always_comb begin
        n_clr_cnt   = r_clr_cnt;
        n_head      = r_head;
        n_tally     = r_tally;
        n_fresh     = r_fresh;
        n_target    = r_target;
        n_backlog   = r_backlog;
        n_grow_left = r_grow_left;
        n_exh       = r_exh;
        s_grow_go   = 1'b0;
        s_load      = 1'b0;
        s_ok        = 1'b0;
        s_gid       = '0;
        s_exh       = 1'b0;
        fl_we       = 1'b0;
        fl_waddr    = push_addr;
        fl_wdata    = r_rid;
        ho_we       = 1'b0;
        ho_waddr    = r_rid;
        ho_wdata    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                // Sweep both memories to zero
                fl_we     = 1'b1;
                fl_waddr  = r_clr_cnt;
                fl_wdata  = '0;
                ho_we     = 1'b1;
                ho_waddr  = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + ID_W'(1);
            end
            ST_EXEC: begin
                case (r_cmd)
                    CMD_RENT: begin
                        // Pop the oldest free ID and mark it handed out
                        s_load = 1'b1;
                        if (r_tally != '0) begin
                            s_ok     = 1'b1;
                            s_gid    = r_fl_rdata;
                            ho_we    = 1'b1;
                            ho_waddr = r_fl_rdata;
                            ho_wdata = 1'b1;
                            n_head   = r_head + ID_W'(1);
                            n_tally  = r_tally - CNT_W'(1);
                        end
                    end
                    CMD_RETURN: begin
                        // Retire against the backlog, else queue at the tail
                        s_load = 1'b1;
                        if (r_ho_rdata) begin
                            s_ok  = 1'b1;
                            ho_we = 1'b1;
                            if (r_backlog != '0) begin
                                n_backlog = r_backlog - CNT_W'(1);
                            end else if (r_tally < POOL_MAX) begin
                                fl_we   = 1'b1;
                                n_tally = r_tally + CNT_W'(1);
                            end
                        end
                    end
                    CMD_RESIZE: begin
                        n_target = nsz_sat;
                        if (nsz_sat > r_target) begin
                            n_exh       = need > avail;
                            n_grow_left = grow_cnt;
                            if (grow_cnt != '0) begin
                                s_grow_go = 1'b1;
                            end else begin
                                s_load = 1'b1;
                                s_ok   = 1'b1;
                                s_exh  = need > avail;
                            end
                        end else begin
                            // Shrink: retire free IDs oldest first in one step
                            s_load = 1'b1;
                            s_ok   = 1'b1;
                            if (nsz_sat < r_target) begin
                                n_backlog = shrink_amt - take;
                                n_head    = r_head + take[ID_W-1:0];
                                n_tally   = r_tally - take;
                            end
                        end
                    end
                    default: begin
                        s_load = 1'b1;
                    end
                endcase
            end
            ST_GROW: begin
                // Mint one fresh ID per cycle into the free list tail
                if (r_tally < POOL_MAX) begin
                    fl_we    = 1'b1;
                    fl_wdata = r_fresh[ID_W-1:0];
                    n_tally  = r_tally + CNT_W'(1);
                end
                n_fresh     = r_fresh + CNT_W'(1);
                n_grow_left = r_grow_left - CNT_W'(1);
                if (r_grow_left == CNT_W'(1)) begin
                    s_load = 1'b1;
                    s_ok   = 1'b1;
                    s_exh  = r_exh;
                end
            end
            default: begin
            end
        endcase
    end

    // Hold or drop the result register
    always_comb begin
        n_m_valid = r_m_valid;
        if (s_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_head      <= '0;
            r_tally     <= CNT_W'(1);
            r_fresh     <= CNT_W'(1);
            r_target    <= CNT_W'(1);
            r_backlog   <= '0;
            r_grow_left <= '0;
            r_exh       <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_head      <= n_head;
            r_tally     <= n_tally;
            r_fresh     <= n_fresh;
            r_target    <= n_target;
            r_backlog   <= n_backlog;
            r_grow_left <= n_grow_left;
            r_exh       <= n_exh;
            r_m_valid   <= n_m_valid;
        end
    end

    // Capture the request and read both memories
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd      <= t_cmd'(i_s_tuser[1:0]);
            r_rid      <= i_s_tdata[7:0];
            r_nsz      <= i_s_tdata[16:8];
            r_fl_rdata <= fl_mem[r_head];
            r_ho_rdata <= ho_mem[i_s_tdata[7:0]];
        end
    end

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            fl_mem[fl_waddr] <= fl_wdata;
        end
        if (ho_we) begin
            ho_mem[ho_waddr] <= ho_wdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_m_tdata <= {3'b000, s_exh, n_backlog, n_target, n_tally, s_gid, s_ok};
        end
    end

endmodule
